// File: src/lfu_pkg.sv
// ---------------------------------------------------------------------------
// lfu_pkg
// shared constants and types for the lfu page replacement block
// ---------------------------------------------------------------------------
package lfu_pkg;

  localparam int FRAME_SLOTS = 8;
  localparam int PAGE_BITS   = 16;
  localparam int CNT_W       = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 4;
  localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int NUM_W       = $clog2(FRAME_SLOTS + 1) + 1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [NUM_W-1:0]     num_t;

  // search word that walks the cell row, one cell per cycle
  typedef struct packed {
    logic  vld;
    page_t page;
    num_t  n;
    logic  found;
    slot_t hit_slot;
    logic  empty_found;
    slot_t empty_slot;
    logic  best_set;
    slot_t best_slot;
    cnt_t  best_count;
    time_t best_last;
    page_t best_page;
  } scan_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic  we;
    logic  load;
    slot_t slot;
    page_t page;
    time_t idx;
  } upd_t;

endpackage

// File: src/lfu_page_replacement.sv
// ---------------------------------------------------------------------------
// lfu_page_replacement
// least-frequently-used page replacement with least-recently-used tie break
// ---------------------------------------------------------------------------
//
//   channel    | ports                                          | flow
//   -----------+------------------------------------------------+--------------
//   reference  | start, busy, page_number                       | start & !busy
//   result     | done, hit, slot, evicted, evicted_page,        | done strobe,
//              | fault_total                                    | one cycle
//   config     | cfg_we, frames_in_use                          | cfg_we
//
// in a reference beat the search word walks the row of frame cells one cell
// per cycle, the decision on the tail word writes the chosen frame at the
// edge that raises done, and done is high in the beat's last cycle.
// busy drops at the edge that raises done, so the next beat can be accepted
// at the edge that ends the done cycle.
// rst is synchronous: all frames empty, counters zero, frames_in_use back to
// its full count. done cannot be held off; the receiver takes it as it comes.
// ---------------------------------------------------------------------------
module lfu_page_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page_number,
  input  logic        cfg_we,
  input  logic [3:0]  frames_in_use,
  output logic        done,
  output logic        hit,
  output logic [2:0]  slot,
  output logic        evicted,
  output logic [15:0] evicted_page,
  output logic [31:0] fault_total
);

  // configuration register
  logic [lfu_pkg::CFG_W-1:0] frames_cfg;
  lfu_pkg::num_t             n_active;

  // running counters
  lfu_pkg::time_t ref_index;
  logic [31:0]    fault_count;
  logic [31:0]    fault_count_next;

  // cell row
  lfu_pkg::scan_t chain [lfu_pkg::FRAME_SLOTS+1];
  lfu_pkg::scan_t scan_head;
  lfu_pkg::scan_t tail;
  lfu_pkg::upd_t  upd;

  // decision on the tail word
  logic           dec_hit;
  lfu_pkg::slot_t dec_slot;
  logic           dec_evict;
  lfu_pkg::page_t dec_old;

  logic accept;

  assign accept = start && !busy;

  // zero acts as one frame, anything past the row acts as the whole row
  always_comb begin
    if (frames_cfg == '0) begin
      n_active = lfu_pkg::num_t'(1);
    end else if (lfu_pkg::num_t'(frames_cfg) > lfu_pkg::num_t'(lfu_pkg::FRAME_SLOTS)) begin
      n_active = lfu_pkg::num_t'(lfu_pkg::FRAME_SLOTS);
    end else begin
      n_active = lfu_pkg::num_t'(frames_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= lfu_pkg::CFG_W'(lfu_pkg::FRAME_SLOTS);
    end else if (cfg_we) begin
      frames_cfg <= frames_in_use;
    end
  end

  // launch the search word into cell zero
  always_comb begin
    scan_head             = '0;
    scan_head.vld         = 1'b1;
    scan_head.page        = lfu_pkg::page_t'(page_number);
    scan_head.n           = n_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (accept) begin
      chain[0] <= scan_head;
    end else begin
      chain[0].vld <= 1'b0;
    end
  end

  for (genvar i = 0; i < lfu_pkg::FRAME_SLOTS; i++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_id  (lfu_pkg::slot_t'(i)),
      .scan_in  (chain[i]),
      .upd      (upd),
      .scan_out (chain[i+1])
    );
  end

  assign tail = chain[lfu_pkg::FRAME_SLOTS];

  // hit first, then the lowest empty frame, then the least used victim
  always_comb begin
    dec_hit   = tail.found;
    dec_evict = 1'b0;
    dec_old   = '0;
    if (tail.found) begin
      dec_slot = tail.hit_slot;
    end else if (tail.empty_found) begin
      dec_slot = tail.empty_slot;
    end else begin
      dec_slot  = tail.best_slot;
      dec_evict = 1'b1;
      dec_old   = tail.best_page;
    end
  end

  always_comb begin
    upd.we   = tail.vld;
    upd.load = !dec_hit;
    upd.slot = dec_slot;
    upd.page = tail.page;
    upd.idx  = ref_index;
  end

  always_comb begin
    fault_count_next = fault_count;
    if (!dec_hit && (fault_count != '1)) begin
      fault_count_next = fault_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      ref_index   <= '0;
      fault_count <= '0;
    end else begin
      done <= tail.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.vld) begin
        busy <= 1'b0;
      end
      if (tail.vld) begin
        fault_count <= fault_count_next;
        if (ref_index != '1) begin
          ref_index <= ref_index + lfu_pkg::time_t'(1);
        end
      end
    end
  end

  // result payload, held until the next beat
  always_ff @(posedge clk) begin
    if (tail.vld) begin
      hit          <= dec_hit;
      slot         <= 3'(dec_slot);
      evicted      <= dec_evict;
      evicted_page <= 16'(dec_old);
      fault_total  <= fault_count_next;
    end
  end

endmodule

// File: src/lfu_cell.sv
// ---------------------------------------------------------------------------
// lfu_cell
// one page frame: holds its page, count and last use, merges its view into
// the passing search word and registers it toward the next cell
// ---------------------------------------------------------------------------
module lfu_cell (
  input  logic           clk,
  input  logic           rst,
  input  lfu_pkg::slot_t slot_id,
  input  lfu_pkg::scan_t scan_in,
  input  lfu_pkg::upd_t  upd,
  output lfu_pkg::scan_t scan_out
);

  lfu_pkg::page_t page;
  logic           valid;
  lfu_pkg::cnt_t  count;
  lfu_pkg::time_t last;
  lfu_pkg::scan_t scan_next;
  logic           in_range;
  logic           mine;

  assign in_range = lfu_pkg::num_t'(slot_id) < scan_in.n;
  assign mine     = upd.we && (upd.slot == slot_id);

  always_comb begin
    scan_next = scan_in;
    if (in_range) begin
      if (valid && (page == scan_in.page) && !scan_in.found) begin
        scan_next.found    = 1'b1;
        scan_next.hit_slot = slot_id;
      end
      if (!valid && !scan_in.empty_found) begin
        scan_next.empty_found = 1'b1;
        scan_next.empty_slot  = slot_id;
      end
      // lowest count, then earliest last use; lower slot wins a full tie
      if (valid && (!scan_in.best_set || (count < scan_in.best_count) ||
                    ((count == scan_in.best_count) && (last < scan_in.best_last)))) begin
        scan_next.best_set   = 1'b1;
        scan_next.best_slot  = slot_id;
        scan_next.best_count = count;
        scan_next.best_last  = last;
        scan_next.best_page  = page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.vld <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
      last  <= '0;
    end else if (mine) begin
      last <= upd.idx;
      if (upd.load) begin
        valid <= 1'b1;
        count <= lfu_pkg::cnt_t'(1);
      end else if (count != '1) begin
        count <= count + lfu_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mine && upd.load) begin
      page <= upd.page;
    end
  end

endmodule

// File: tb/sv/lfu_checker.sv
// ---------------------------------------------------------------------------
// lfu_checker
// watches the reference, result and config channels of the lfu block, keeps
// its own frame table to work out each result, and compares field by field
// ---------------------------------------------------------------------------
module lfu_checker
  import lfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] page_number,
  input  logic        cfg_we,
  input  logic [3:0]  frames_in_use,
  input  logic        done,
  input  logic        hit,
  input  logic [2:0]  slot,
  input  logic        evicted,
  input  logic [15:0] evicted_page,
  input  logic [31:0] fault_total,
  output int          errors,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    slot_t       slot;
    logic        evicted;
    page_t       evicted_page;
    logic [31:0] fault_total;
  } outcome_t;

  // shadow frame table
  page_t            frame_page  [FRAME_SLOTS];
  logic             frame_used  [FRAME_SLOTS];
  cnt_t             frame_count [FRAME_SLOTS];
  time_t            frame_last  [FRAME_SLOTS];
  time_t            ref_idx;
  logic [31:0]      faults;
  logic [CFG_W-1:0] frames_cfg;

  outcome_t expected_q [$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic clear_table();
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      frame_page[s]  = '0;
      frame_used[s]  = 1'b0;
      frame_count[s] = '0;
      frame_last[s]  = '0;
    end
    ref_idx    = '0;
    faults     = '0;
    frames_cfg = CFG_W'(FRAME_SLOTS);
    expected_q.delete();
  endtask

  // lookup, then empty fill, then lowest count / oldest use / lowest slot
  task automatic predict_reference(input page_t p);
    int       n;
    int       where;
    logic     found;
    logic     empty;
    outcome_t o;
    n     = (frames_cfg == 0) ? 1 : (frames_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_cfg);
    found = 1'b0;
    empty = 1'b0;
    where = 0;
    o     = '0;
    for (int s = 0; s < n; s++)
      if (!found && frame_used[s] && frame_page[s] == p) begin
        found = 1'b1;
        where = s;
      end
    if (found) begin
      if (frame_count[where] != '1) frame_count[where]++;
      frame_last[where] = ref_idx;
    end else begin
      for (int s = 0; s < n; s++)
        if (!empty && !frame_used[s]) begin
          empty = 1'b1;
          where = s;
        end
      if (!empty) begin
        where = 0;
        for (int s = 1; s < n; s++)
          if (frame_count[s] < frame_count[where] ||
              (frame_count[s] == frame_count[where] && frame_last[s] < frame_last[where]))
            where = s;
        o.evicted      = 1'b1;
        o.evicted_page = frame_page[where];
      end
      frame_page[where]  = p;
      frame_used[where]  = 1'b1;
      frame_count[where] = cnt_t'(1);
      frame_last[where]  = ref_idx;
      if (faults != '1) faults++;
    end
    if (ref_idx != '1) ref_idx++;
    o.hit         = found;
    o.slot        = slot_t'(where);
    o.fault_total = faults;
    expected_q.push_back(o);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result beat with none expected, actual hit %0b slot %0d page %0h total %0d",
               $time, hit, slot, evicted_page, fault_total);
      errors++;
    end else begin
      want = expected_q.pop_front();
      compare_field("hit",          32'(want.hit),          32'(hit));
      compare_field("slot",         32'(want.slot),         32'(slot));
      compare_field("evicted",      32'(want.evicted),      32'(evicted));
      compare_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
      compare_field("fault_total",  want.fault_total,       fault_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
    end else begin
      if (cfg_we) frames_cfg = frames_in_use;
      if (start && !busy) predict_reference(page_number);
      if (done) check_outcome();
    end
    outstanding <= expected_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives page references into the lfu page replacement block: a directed
// walk through fill, hit, eviction and frame count corners, then random
// reference streams over small working sets under several frame counts and
// sender idle rates
// ---------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  // generous watchdog limit for a full run
  localparam longint CYCLE_LIMIT = 200_000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic [15:0] page_number   = '0;
  logic        cfg_we        = 1'b0;
  logic [3:0]  frames_in_use = 4'd8;
  logic        busy;
  logic        done;
  logic        hit;
  logic [2:0]  slot;
  logic        evicted;
  logic [15:0] evicted_page;
  logic [31:0] fault_total;

  int     errors;
  int     outstanding;
  int     gap_pct = 0;
  longint cycles  = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lfu_page_replacement u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .cfg_we       (cfg_we),
    .frames_in_use(frames_in_use),
    .done         (done),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .fault_total  (fault_total)
  );

  // predicts and compares every result beat
  lfu_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .cfg_we       (cfg_we),
    .frames_in_use(frames_in_use),
    .done         (done),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .fault_total  (fault_total),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one reference beat; start stays high after the accept so back-to-back
  // beats never lower and raise it in the same step, and the idle draw may
  // drop it while the block is still busy or right after done
  task automatic send_ref(input logic [15:0] p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    page_number <= p;
    do @(posedge clk); while (busy);
  endtask

  // quiet the sender and wait for every predicted result to come back
  // (one edge first so a beat accepted on this edge is already counted)
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // frame count change, only with the block idle
  task automatic write_frames(input logic [3:0] v);
    wait_idle();
    cfg_we        <= 1'b1;
    frames_in_use <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] pool [16];
    int          pool_n;
    logic [3:0]  fsel;

    // synchronous reset
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, no idling, reset frame count of eight ----
    gap_pct = 0;
    // fill every frame, extremes of the page field among them
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'hAAAA);
    send_ref(16'h5555);
    send_ref(16'h8000);
    send_ref(16'h7FFF);
    send_ref(16'h0001);
    send_ref(16'h1234);
    // hits raise counts on slots 0 and 1
    send_ref(16'hFFFF);
    send_ref(16'hFFFF);
    send_ref(16'h0000);
    // misses: count-one frames lose, oldest use goes first
    send_ref(16'h4242);
    send_ref(16'h4243);

    // zero frames acts as one: slot 0 only, the rest keep their pages
    write_frames(4'd0);
    send_ref(16'h0000);
    send_ref(16'hFFFF);

    // above the frame count acts as eight: 0xffff now sits in slots 0 and 1,
    // lookup must pick the lower one
    write_frames(4'd15);
    send_ref(16'hFFFF);
    send_ref(16'h7FFF);
    send_ref(16'h9999);

    // ---- random streams: sender idles 38%, then 73%, then never ----
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 38 : (ph == 1) ? 73 : 0;
      for (int sub = 0; sub < 5; sub++) begin
        case (sub)
          0:       fsel = 4'd1;
          1:       fsel = 4'd8;
          3:       fsel = 4'($urandom_range(2, 7));
          default: fsel = 4'($urandom_range(15));
        endcase
        write_frames(fsel);
        // small working set so hits and count ordering matter
        pool_n = $urandom_range(2, 14);
        for (int k = 0; k < 16; k++) begin
          case ($urandom_range(7))
            0:       pool[k] = 16'h0000;
            1:       pool[k] = 16'hFFFF;
            default: pool[k] = 16'($urandom_range(16'hFFFF));
          endcase
        end
        // mostly working set pages, some fresh pages as noise
        for (int i = 0; i < 109; i++) begin
          if ($urandom_range(99) < 85)
            send_ref(pool[$urandom_range(pool_n - 1)]);
          else
            send_ref(16'($urandom_range(16'hFFFF)));
        end
      end
    end

    // drain, then wait for any stray beat
    wait_idle();
    repeat (4 * (FRAME_SLOTS + 2)) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
